/* rtl/core/nec_ir_frame_decoder_assert.svh */
// ----------------------------------------------------------------------------
// NEC IR frame decoder assertion macros
// Shared property forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, off while reset is high
`define NIR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nec_ir_frame_decoder: check failed");

// Next-cycle implication, off while reset is high
`define NIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nec_ir_frame_decoder: check failed");

// Same-cycle implication, active through reset
`define NIR_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("nec_ir_frame_decoder: check failed");

`endif

/* rtl/core/nir_pkg.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package nir_pkg;

   localparam int FRAME_BITS_DEF = 32;
   localparam int TICK_W         = 8;
   localparam int INDEX_W        = 8;
   localparam int CODE_W         = 32;
   localparam int CSR_INDEX_W    = 1;
   localparam int CSR_DATA_W     = 8;
   localparam int REQ_DATA_W     = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SOF_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_THRESHOLD = 1'b1;

   // Register reset values
   localparam logic [TICK_W-1:0] SOF_THRESHOLD_RST = 8'd25;
   localparam logic [TICK_W-1:0] ONE_THRESHOLD_RST = 8'd4;

   // Counter limits and marks
   localparam logic [TICK_W-1:0]  TICK_MAX    = 8'hFF;
   localparam logic [INDEX_W-1:0] INDEX_START = 8'hFF;

   typedef struct packed {
      logic [TICK_W-1:0] sof_threshold;
      logic [TICK_W-1:0] one_threshold;
   } nir_cfg_type;

   typedef struct packed {
      logic fire;
      logic pin_level;
   } nir_step_type;

   typedef struct packed {
      logic              key_valid;
      logic [CODE_W-1:0] key_code;
   } nir_key_type;

endpackage

/* rtl/core/nec_ir_frame_decoder.sv */
// ----------------------------------------------------------------------------
// NEC IR frame decoder
// Decodes NEC frames from a stream of sampled IR receiver pin levels.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         tdata[0] pin_level, one sample per request
// rsp      out        tuser[0] key_valid, tdata[31:0] key_code, one per request
// csr      in         write only: index 0 sof_threshold, index 1 one_threshold
//
// Every request yields one response; one request per cycle is sustained while
// rsp_tready is high. A sample passes an input register, then the decode logic
// into the output register. The output register stalls on rsp_tready, and the
// input register fills behind it before req_tready drops.
// Reset clears all but the data registers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder
   import nir_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [0] pin_level, [7:1] zero
   // Response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [CODE_W-1:0]      rsp_tdata,   // [31:0] key_code
   output logic                   rsp_tuser,   // [0] key_valid
   // Configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   nir_cfg_type       cfg_ff;
   logic              in_valid_ff;
   logic              in_pin_ff;
   logic              out_valid_ff;
   logic              out_key_valid_ff;
   logic [CODE_W-1:0] out_code_ff;
   logic              advance;
   nir_step_type      step;
   nir_key_type       key;

   // Move a sample forward when the output register is free
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step.fire      = in_valid_ff && advance;
   assign step.pin_level = in_pin_ff;

   // Decode threshold writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sof_threshold <= SOF_THRESHOLD_RST;
         cfg_ff.one_threshold <= ONE_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SOF_THRESHOLD: cfg_ff.sof_threshold <= csr_wdata;
            CSR_ONE_THRESHOLD: cfg_ff.one_threshold <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_pin_ff <= req_tdata[0];
      end
   end

   nir_decode_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .step  (step),
      .key   (key)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire) begin
         out_key_valid_ff <= key.key_valid;
         out_code_ff      <= key.key_code;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_key_valid_ff;
   assign rsp_tdata  = out_code_ff;

endmodule

/* rtl/core/nir_decode_core.sv */
// ----------------------------------------------------------------------------
// NEC IR decode core
// Edge detection, gap timing and bit assembly for one pin sample per step.
// ----------------------------------------------------------------------------
module nir_decode_core
   import nir_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  nir_cfg_type  cfg,
   input  nir_step_type step,
   output nir_key_type  key
);

   localparam int POS_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam logic [POS_W-1:0]      LAST_POS  = POS_W'(FRAME_BITS - 1);
   localparam logic [INDEX_W-1:0]    LAST_IDX  = INDEX_W'(FRAME_BITS - 1);
   localparam logic [INDEX_W-1:0]    FRAME_IDX = INDEX_W'(FRAME_BITS);
   localparam logic [FRAME_BITS-1:0] ONE_BIT   = FRAME_BITS'(1);

   logic [TICK_W-1:0]     tick_ff, tick_in, tick_inc;
   logic [INDEX_W-1:0]    index_ff, index_in, index_inc;
   logic [FRAME_BITS-1:0] pattern_ff, pattern_in, pattern_set;
   logic                  last_ff;
   logic                  fall;
   logic [POS_W-1:0]      bit_pos;

   // Saturate the gap counter, then look for a falling edge
   assign tick_inc  = (tick_ff == TICK_MAX) ? tick_ff : tick_ff + 1'b1;
   assign fall      = !step.pin_level && last_ff;
   assign index_inc = index_ff + 1'b1;
   assign bit_pos   = LAST_POS - index_inc[POS_W-1:0];

   always_comb begin
      tick_in       = tick_ff;
      index_in      = index_ff;
      pattern_in    = pattern_ff;
      pattern_set   = pattern_ff;
      key.key_valid = 1'b0;
      key.key_code  = '0;
      if (step.fire) begin
         tick_in = tick_inc;
         if (fall) begin
            tick_in  = '0;
            index_in = index_inc;
            if (tick_inc >= cfg.sof_threshold) begin
               // Start of frame: restart the index so the next edge gives the first bit
               index_in   = INDEX_START;
               pattern_in = '0;
            end else if (index_inc < FRAME_IDX) begin
               if (tick_inc >= cfg.one_threshold) begin
                  pattern_set = pattern_ff | (ONE_BIT << bit_pos);
               end
               pattern_in = pattern_set;
               if (index_inc == LAST_IDX) begin
                  key.key_valid = 1'b1;
                  key.key_code  = CODE_W'(pattern_set);
                  index_in      = '0;
               end
            end
         end
      end
   end

   // Hold decoder state between samples
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         index_ff   <= '0;
         pattern_ff <= '0;
         last_ff    <= 1'b1;
      end else begin
         tick_ff    <= tick_in;
         index_ff   <= index_in;
         pattern_ff <= pattern_in;
         if (step.fire) begin
            last_ff <= step.pin_level;
         end
      end
   end

endmodule

/* rtl/core/nir_checker.sv */
// ----------------------------------------------------------------------------
// NEC IR decoder checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_decoder_assert.svh"

module nir_checker
   import nir_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_DATA_W-1:0]  req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [CODE_W-1:0]      rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   csr_we,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic rsp_stall;
   logic req_fire;
   logic csr_touch;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign req_fire  = req_tvalid && req_tready;
   assign csr_touch = csr_we && (csr_index == CSR_SOF_THRESHOLD || csr_wdata != '0);

   // A response without a key carries a zero code
   `NIR_ASSERT_IMPLY(a_code_zero_idle, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

   // A stalled response holds its contents
   `NIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Nothing comes out right after reset
   `NIR_ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset), !rsp_tvalid)

   // With the output free and nothing pending, the input side is open
   `NIR_ASSERT_NEXT(a_req_open, clock, reset, !req_fire && !rsp_tvalid && !csr_touch && req_tready, req_tready)

endmodule

bind nec_ir_frame_decoder nir_checker u_checker (.*);

/* test/nec_ir_frame_decoder_tb.sv */
// ----------------------------------------------------------------------------
// NEC IR frame decoder testbench
// Streams pin samples built into NEC style frames, broken frames, bare edge
// runs and noise through the decoder under several threshold settings. A
// scoreboard predicts the response to every accepted request and checks each
// response in order, field by field, while both stream sides stall at random.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_tb
   import nir_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // -------------------------------------------------------------------------
   // Scoreboard: decoder state and thresholds, queue of expected keys
   // -------------------------------------------------------------------------
   class nec_key_scoreboard;
      logic [TICK_W-1:0]  sof_threshold;
      logic [TICK_W-1:0]  one_threshold;
      logic [TICK_W-1:0]  tick_count;
      logic [INDEX_W-1:0] pulse_index;
      logic [CODE_W-1:0]  bit_pattern;
      logic               last_level;
      nir_key_type        expected_keys[$];
      int                 errors;

      function new();
         sof_threshold = SOF_THRESHOLD_RST;
         one_threshold = ONE_THRESHOLD_RST;
         tick_count    = '0;
         pulse_index   = '0;
         bit_pattern   = '0;
         last_level    = 1'b1;
         errors        = 0;
      endfunction

      function void write_threshold(logic [CSR_INDEX_W-1:0] index,
                                    logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_SOF_THRESHOLD: sof_threshold = value;
            CSR_ONE_THRESHOLD: one_threshold = value;
            default: ;
         endcase
      endfunction

      // Advance the decoder by one accepted pin sample and queue its key
      function void note_sample(logic pin);
         nir_key_type key;
         key = '0;
         if (tick_count != TICK_MAX) tick_count++;
         if (pin && !last_level) begin
            last_level = 1'b1;
         end else if (!pin && last_level) begin
            last_level = 1'b0;
            pulse_index++;
            if (tick_count >= sof_threshold) begin
               // frame start: restart the index and clear the pattern
               pulse_index = INDEX_START;
               bit_pattern = '0;
            end else if (!pulse_index[INDEX_W-1] && pulse_index < FRAME_BITS_DEF) begin
               if (tick_count >= one_threshold)
                  bit_pattern[FRAME_BITS_DEF-1-pulse_index] = 1'b1;
               if (pulse_index == FRAME_BITS_DEF-1) begin
                  key.key_valid = 1'b1;
                  key.key_code  = bit_pattern;
                  pulse_index   = '0;
               end
            end
            tick_count = '0;
         end
         expected_keys.push_back(key);
      endfunction

      // Compare one response with the oldest expected key
      function void check_key(logic valid, logic [CODE_W-1:0] code);
         nir_key_type want;
         if (expected_keys.size() == 0) begin
            $error("unexpected response: key_valid %0d key_code %h", valid, code);
            errors++;
            return;
         end
         want = expected_keys.pop_front();
         if (valid !== want.key_valid) begin
            $error("key_valid: expected %0d actual %0d", want.key_valid, valid);
            errors++;
         end
         if (code !== want.key_code) begin
            $error("key_code: expected %h actual %h", want.key_code, code);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CODE_W-1:0]      rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   nec_key_scoreboard key_board;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int cur_sof       = int'(SOF_THRESHOLD_RST);
   int cur_one       = int'(ONE_THRESHOLD_RST);
   int sent_samples  = 0;

   nec_ir_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         key_board.check_key(rsp_tuser, rsp_tdata);
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks
   // -------------------------------------------------------------------------

   // Offer one pin sample, with random gaps ahead of it, and hold until taken
   task automatic send_sample(logic pin);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      key_board.note_sample(pin);
      sent_samples++;
   endtask

   task automatic send_level(logic level, int count);
      repeat (count) send_sample(level);
   endtask

   // One low-then-high pulse; its length is the gap to the next falling edge
   task automatic send_pulse(int len);
      int low_len;
      low_len = $urandom_range(len - 1, 1);
      send_level(1'b0, low_len);
      send_level(1'b1, len - low_len);
   endtask

   // Pulse length that should decode as the given bit under current thresholds
   function automatic int pulse_len(logic one_bit);
      int lo;
      int hi;
      if (one_bit) begin
         lo = (cur_one < 2) ? 2 : cur_one;
         hi = lo + 3;
         if (cur_sof > lo && cur_sof - 1 < hi) hi = cur_sof - 1;
      end else begin
         lo = 2;
         hi = (cur_one > 3) ? cur_one - 1 : 2;
         if (hi > 5) hi = 5;
      end
      return $urandom_range(hi, lo);
   endfunction

   // Long high lead for the start edge, then pulses carrying the code MSB first
   task automatic send_frame(logic [CODE_W-1:0] code, int pulses);
      send_level(1'b1, cur_sof + $urandom_range(3));
      for (int j = 0; j < pulses; j++) begin
         if (j < FRAME_BITS_DEF) send_pulse(pulse_len(code[FRAME_BITS_DEF-1-j]));
         else send_pulse(pulse_len(1'($urandom_range(1))));
      end
   endtask

   // Mostly whole frames; the rest broken frames, bare edge runs and noise
   task automatic send_random_burst();
      int pick;
      pick = $urandom_range(99);
      if (pick < 65) begin
         send_frame($urandom, FRAME_BITS_DEF + 1);
      end else if (pick < 80) begin
         send_frame($urandom, $urandom_range(FRAME_BITS_DEF, 1));
      end else if (pick < 90) begin
         repeat ($urandom_range(40, 1)) send_pulse(pulse_len(1'($urandom_range(1))));
      end else begin
         repeat ($urandom_range(20, 1)) send_sample(1'($urandom_range(1)));
      end
   endtask

   // Hold requests until every expected key has come back, then settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (key_board.expected_keys.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_thresholds(int sof, int one);
      csr_we    <= 1'b1;
      csr_index <= CSR_SOF_THRESHOLD;
      csr_wdata <= sof[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_index <= CSR_ONE_THRESHOLD;
      csr_wdata <= one[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      key_board.write_threshold(CSR_SOF_THRESHOLD, sof[CSR_DATA_W-1:0]);
      key_board.write_threshold(CSR_ONE_THRESHOLD, one[CSR_DATA_W-1:0]);
      cur_sof = sof;
      cur_one = one;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      key_board     = new();
      req_gap_pct   = 16;
      rsp_stall_pct = 88;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset thresholds: edges before any start
      send_sample(1'b0);
      send_sample(1'b1);
      send_sample(1'b0);
      send_sample(1'b1);
      // frame of zeros, frame with both end bits set, then edges that reuse
      // the old pattern
      send_frame('0, FRAME_BITS_DEF + 1);
      send_frame(32'h8000_0001, FRAME_BITS_DEF + 1);
      repeat (FRAME_BITS_DEF) send_pulse(pulse_len(1'b0));
      wait_idle();

      // Zero thresholds: every falling edge starts a frame
      set_thresholds(0, 0);
      repeat (12) send_sample(1'($urandom_range(1)));
      send_frame(32'hA5A5_5A5A, FRAME_BITS_DEF + 1);
      wait_idle();

      // Top start threshold: start needs a saturated gap
      set_thresholds(255, 1);
      send_frame('0, 2);
      wait_idle();
      set_thresholds(1, 255);
      repeat (20) send_sample(1'($urandom_range(1)));
      wait_idle();

      // Random part, sender mostly idle
      req_gap_pct   = 88;
      rsp_stall_pct = 16;
      set_thresholds(6, 3);
      begin
         int target;
         target = sent_samples + 60;
         while (sent_samples < target) send_random_burst();
      end
      wait_idle();

      // Random part, no idling on either side
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      set_thresholds(12, 5);
      begin
         int target;
         target = sent_samples + 40;
         while (sent_samples < target) send_random_burst();
      end
      wait_idle();
      set_thresholds(4, 2);
      begin
         int target;
         target = sent_samples + 20;
         while (sent_samples < target) send_random_burst();
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (key_board.errors == 0) begin
         $display("nec_ir_frame_decoder_tb: PASS");
      end else begin
         $display("nec_ir_frame_decoder_tb: FAIL");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #20_000_000;
      $display("nec_ir_frame_decoder_tb: FAIL");
      $finish;
   end

endmodule
